[rtl/sscc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sscc_pkg;

    // field and register widths
    localparam int unsigned ACTION_W        = 2;
    localparam int unsigned COIL_W          = 4;
    localparam int unsigned MODE_W          = 2;
    localparam int unsigned PHASE_W         = 3;
    localparam int unsigned STEP_INTERVAL_W = 20;
    localparam int unsigned BLINK_PERIOD_W  = 20;
    localparam int unsigned END_WAIT_W      = 24;
    localparam int unsigned CFG_IDX_W       = 2;
    localparam int unsigned CFG_DATA_W      = 24;

    // parameter defaults
    localparam int unsigned STEP_COUNT_BITS_DEF = 16;
    localparam int unsigned TIMER_BITS_DEF      = 24;

    // register reset values
    localparam logic [STEP_INTERVAL_W-1:0] STEP_INTERVAL_RST = STEP_INTERVAL_W'(2000);
    localparam logic [BLINK_PERIOD_W-1:0]  BLINK_PERIOD_RST  = BLINK_PERIOD_W'(250000);
    localparam logic [END_WAIT_W-1:0]      END_WAIT_RST      = END_WAIT_W'(3000000);

    // button actions
    typedef enum logic [ACTION_W-1:0] {
        ACT_NONE  = 2'd0,
        ACT_PRESS = 2'd1,
        ACT_LONG  = 2'd2
    } t_action;

    // controller modes
    typedef enum logic [MODE_W-1:0] {
        MODE_IDLE  = 2'd0,
        MODE_ARMED = 2'd1,
        MODE_CALIB = 2'd2,
        MODE_RUN   = 2'd3
    } t_mode;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_INTERVAL = 2'd0,
        CFG_BLINK_PERIOD  = 2'd1,
        CFG_END_WAIT      = 2'd2
    } t_cfg_idx;

    // timer clear requests from the controller
    typedef struct packed {
        logic step;
        logic blink;
        logic wait_end;
    } t_tmr_clr;

    // half-step coil pattern for each phase
    function automatic logic [COIL_W-1:0] half_step_pattern(input logic [PHASE_W-1:0] phase);
        logic [COIL_W-1:0] pat;
        unique case (phase)
            3'd0: pat = 4'h1;
            3'd1: pat = 4'h3;
            3'd2: pat = 4'h2;
            3'd3: pat = 4'h6;
            3'd4: pat = 4'h4;
            3'd5: pat = 4'hC;
            3'd6: pat = 4'h8;
            default: pat = 4'h9;
        endcase
        return pat;
    endfunction

endpackage

`default_nettype wire

[rtl/sscc_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface sscc_in_if;
    import sscc_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] button_action;

    modport source (output valid, output button_action, input ready);
    modport sink   (input valid, input button_action, output ready);
endinterface

`default_nettype wire

[rtl/sscc_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface sscc_out_if;
    import sscc_pkg::*;

    logic              valid;
    logic              ready;
    logic [COIL_W-1:0] coil_drive;
    logic              status_led;
    logic [MODE_W-1:0] ctrl_mode;
    logic              stepped;

    modport source (output valid, output coil_drive, output status_led,
                    output ctrl_mode, output stepped, input ready);
    modport sink   (input valid, input coil_drive, input status_led,
                    input ctrl_mode, input stepped, output ready);
endinterface

`default_nettype wire

[rtl/sscc_timer.sv]
`timescale 1ns / 1ps
`default_nettype none

module sscc_timer #(
    parameter int unsigned TIMER_BITS = sscc_pkg::TIMER_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_tick,
    input  wire logic                  i_clear,
    output logic      [TIMER_BITS-1:0] o_elapsed
);
    logic [TIMER_BITS-1:0] r_count;
    logic [TIMER_BITS-1:0] n_count;

    // saturating increment, seen by the controller on this tick
    always_comb begin
        o_elapsed = (r_count == {TIMER_BITS{1'b1}}) ? r_count : r_count + 1'b1;
        n_count   = i_clear ? '0 : o_elapsed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_tick) begin
            r_count <= n_count;
        end
    end
endmodule

`default_nettype wire

[rtl/sscc_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module sscc_ctrl #(
    parameter int unsigned STEP_COUNT_BITS = sscc_pkg::STEP_COUNT_BITS_DEF,
    parameter int unsigned TIMER_BITS      = sscc_pkg::TIMER_BITS_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_tick,
    input  wire logic [sscc_pkg::ACTION_W-1:0]        i_action,
    input  wire logic [sscc_pkg::STEP_INTERVAL_W-1:0] i_step_interval,
    input  wire logic [sscc_pkg::BLINK_PERIOD_W-1:0]  i_blink_period,
    input  wire logic [sscc_pkg::END_WAIT_W-1:0]      i_end_wait,
    input  wire logic [TIMER_BITS-1:0]                i_step_elapsed,
    input  wire logic [TIMER_BITS-1:0]                i_blink_elapsed,
    input  wire logic [TIMER_BITS-1:0]                i_wait_elapsed,
    output sscc_pkg::t_tmr_clr                        o_clr,
    output logic      [sscc_pkg::COIL_W-1:0]          o_coil_drive,
    output logic                                      o_status_led,
    output logic      [sscc_pkg::MODE_W-1:0]          o_ctrl_mode,
    output logic                                      o_stepped
);
    import sscc_pkg::*;

    // compare width covers both the timers and the widest register
    localparam int unsigned CMP_W = (TIMER_BITS > END_WAIT_W) ? TIMER_BITS : END_WAIT_W;

    t_mode                      r_state,   n_state;
    logic [PHASE_W-1:0]         r_phase,   n_phase;
    logic [COIL_W-1:0]          r_coil,    n_coil;
    logic [STEP_COUNT_BITS-1:0] r_span,    n_span;
    logic [STEP_COUNT_BITS-1:0] r_left,    n_left;
    logic                       r_heading, n_heading;
    logic                       r_waiting, n_waiting;
    logic                       r_led,     n_led;
    logic                       r_blink,   n_blink;

    logic   press;
    logic   step_due;
    logic   blink_due;
    logic   wait_due;
    logic   stepped;
    t_mode  mode_now;

    // event detection on the incremented timers
    always_comb begin
        press     = (i_action == ACT_PRESS);
        mode_now  = (i_action == ACT_LONG) ? MODE_ARMED : r_state;
        step_due  = CMP_W'(i_step_elapsed)  > CMP_W'(i_step_interval);
        blink_due = CMP_W'(i_blink_elapsed) > CMP_W'(i_blink_period);
        wait_due  = CMP_W'(i_wait_elapsed)  > CMP_W'(i_end_wait);
    end

    // next state and datapath
    always_comb begin
        n_state   = mode_now;
        n_phase   = r_phase;
        n_coil    = r_coil;
        n_span    = r_span;
        n_left    = r_left;
        n_heading = r_heading;
        n_waiting = r_waiting;
        n_led     = r_led;
        n_blink   = r_blink;
        o_clr     = '0;
        stepped   = 1'b0;
        unique case (mode_now)
            MODE_IDLE: begin
                if (press && (r_span != '0)) begin
                    n_led     = 1'b0;
                    n_waiting = 1'b0;
                    n_state   = MODE_RUN;
                end
            end
            MODE_ARMED: begin
                n_led = 1'b1;
                if (press) begin
                    n_span  = '0;
                    n_left  = '0;
                    n_state = MODE_CALIB;
                end
            end
            MODE_CALIB: begin
                if (blink_due) begin
                    n_blink     = ~r_blink;
                    n_led       = ~r_blink;
                    o_clr.blink = 1'b1;
                end
                // calibration always walks backward
                if (step_due) begin
                    n_coil     = half_step_pattern(r_phase);
                    n_phase    = r_phase - 1'b1;
                    o_clr.step = 1'b1;
                    stepped    = 1'b1;
                    n_span     = (r_span == {STEP_COUNT_BITS{1'b1}}) ? r_span : r_span + 1'b1;
                end
                if (press) begin
                    n_left    = n_span;
                    n_heading = 1'b1;
                    n_waiting = 1'b0;
                    n_led     = 1'b0;
                    n_state   = MODE_RUN;
                end
            end
            MODE_RUN: begin
                if (!r_waiting) begin
                    if (step_due) begin
                        n_coil     = half_step_pattern(r_phase);
                        n_phase    = r_heading ? r_phase + 1'b1 : r_phase - 1'b1;
                        o_clr.step = 1'b1;
                        stepped    = 1'b1;
                        if (r_left != '0) begin
                            n_left = r_left - 1'b1;
                        end
                    end
                end else if (wait_due) begin
                    n_waiting = 1'b0;
                end
                // end of travel: reload, turn round and wait
                if (n_left == '0) begin
                    n_left         = r_span;
                    n_heading      = ~r_heading;
                    n_waiting      = 1'b1;
                    o_clr.wait_end = 1'b1;
                end
                if (press) begin
                    n_state = MODE_IDLE;
                    n_coil  = '0;
                end
            end
            default: begin
                n_state = mode_now;
            end
        endcase
    end

    // result word for this tick
    always_comb begin
        o_coil_drive = n_coil;
        o_status_led = n_led;
        o_ctrl_mode  = n_state;
        o_stepped    = stepped;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= MODE_IDLE;
            r_phase   <= '0;
            r_coil    <= '0;
            r_span    <= '0;
            r_left    <= '0;
            r_heading <= 1'b0;
            r_waiting <= 1'b0;
            r_led     <= 1'b0;
            r_blink   <= 1'b0;
        end else if (i_tick) begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_coil    <= n_coil;
            r_span    <= n_span;
            r_left    <= n_left;
            r_heading <= n_heading;
            r_waiting <= n_waiting;
            r_led     <= n_led;
            r_blink   <= n_blink;
        end
    end
endmodule

`default_nettype wire

[rtl/stepper_shuttle_calibrating_controller_unit.sv]
// pipeline: an accepted input word passes the input register, then the result register
// throughput: one word per cycle unless the output stalls; next state is combinational from the state
// registers; a stalled output holds the result register and stalls the input register behind it
// reset: synchronous, active low; mode idle, coils off, led off, timers and counts zero,
// registers back to their default values
`timescale 1ns / 1ps
`default_nettype none

module stepper_shuttle_calibrating_controller_unit #(
    parameter int unsigned STEP_COUNT_BITS = sscc_pkg::STEP_COUNT_BITS_DEF,
    parameter int unsigned TIMER_BITS      = sscc_pkg::TIMER_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [sscc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [sscc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    sscc_in_if.sink                              i_in,
    sscc_out_if.source                           o_out
);
    import sscc_pkg::*;

    logic [STEP_INTERVAL_W-1:0] r_step_interval;
    logic [BLINK_PERIOD_W-1:0]  r_blink_period;
    logic [END_WAIT_W-1:0]      r_end_wait;

    logic                r_in_valid;
    logic [ACTION_W-1:0] r_in_action;

    logic              r_out_valid;
    logic [COIL_W-1:0] r_coil_drive;
    logic              r_status_led;
    logic [MODE_W-1:0] r_ctrl_mode;
    logic              r_stepped;

    logic              tick;
    t_tmr_clr          clr;
    logic [TIMER_BITS-1:0] step_elapsed;
    logic [TIMER_BITS-1:0] blink_elapsed;
    logic [TIMER_BITS-1:0] wait_elapsed;
    logic [COIL_W-1:0] coil_drive;
    logic              status_led;
    logic [MODE_W-1:0] ctrl_mode;
    logic              stepped;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_interval <= STEP_INTERVAL_RST;
            r_blink_period  <= BLINK_PERIOD_RST;
            r_end_wait      <= END_WAIT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_STEP_INTERVAL: r_step_interval <= i_cfg_data[STEP_INTERVAL_W-1:0];
                CFG_BLINK_PERIOD:  r_blink_period  <= i_cfg_data[BLINK_PERIOD_W-1:0];
                CFG_END_WAIT:      r_end_wait      <= i_cfg_data[END_WAIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // pipeline control: a word moves on when the result register frees up
    assign tick       = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || tick;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_action <= i_in.button_action;
        end
    end

    // elapsed tick timers
    sscc_timer #(.TIMER_BITS(TIMER_BITS)) u_step_tmr (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tick    (tick),
        .i_clear   (clr.step),
        .o_elapsed (step_elapsed)
    );

    sscc_timer #(.TIMER_BITS(TIMER_BITS)) u_blink_tmr (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tick    (tick),
        .i_clear   (clr.blink),
        .o_elapsed (blink_elapsed)
    );

    sscc_timer #(.TIMER_BITS(TIMER_BITS)) u_wait_tmr (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tick    (tick),
        .i_clear   (clr.wait_end),
        .o_elapsed (wait_elapsed)
    );

    // mode controller
    sscc_ctrl #(
        .STEP_COUNT_BITS (STEP_COUNT_BITS),
        .TIMER_BITS      (TIMER_BITS)
    ) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_tick          (tick),
        .i_action        (r_in_action),
        .i_step_interval (r_step_interval),
        .i_blink_period  (r_blink_period),
        .i_end_wait      (r_end_wait),
        .i_step_elapsed  (step_elapsed),
        .i_blink_elapsed (blink_elapsed),
        .i_wait_elapsed  (wait_elapsed),
        .o_clr           (clr),
        .o_coil_drive    (coil_drive),
        .o_status_led    (status_led),
        .o_ctrl_mode     (ctrl_mode),
        .o_stepped       (stepped)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (tick) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick) begin
            r_coil_drive <= coil_drive;
            r_status_led <= status_led;
            r_ctrl_mode  <= ctrl_mode;
            r_stepped    <= stepped;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.coil_drive = r_coil_drive;
    assign o_out.status_led = r_status_led;
    assign o_out.ctrl_mode  = r_ctrl_mode;
    assign o_out.stepped    = r_stepped;
endmodule

`default_nettype wire

[rtl/sscc_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module sscc_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_out_valid,
    input wire logic                         i_out_ready,
    input wire logic [sscc_pkg::COIL_W-1:0]  i_coil_drive,
    input wire logic                         i_status_led,
    input wire logic [sscc_pkg::MODE_W-1:0]  i_ctrl_mode,
    input wire logic                         i_stepped
);
    import sscc_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_coil_drive)
            && $stable(i_ctrl_mode) && $stable(i_stepped) && $stable(i_status_led))
        else $error("result word changed while stalled");

    // idle always has the coils released
    a_idle_coils_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_ctrl_mode == MODE_IDLE) |-> (i_coil_drive == '0))
        else $error("coils driven in idle");

    // armed mode never steps; a stop on the same tick as a step ends in idle
    a_step_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_stepped |-> (i_ctrl_mode != MODE_ARMED))
        else $error("step in armed mode");

    // a step drives one or two adjacent coils unless the same tick stopped the motor
    a_step_coils: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_stepped && (i_ctrl_mode != MODE_IDLE) |-> (i_coil_drive != '0))
        else $error("step with coils released");

    // armed mode lights the led
    a_armed_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_ctrl_mode == MODE_ARMED) |-> i_status_led)
        else $error("led dark in armed mode");
endmodule

bind stepper_shuttle_calibrating_controller_unit sscc_checker u_sscc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_coil_drive (o_out.coil_drive),
    .i_status_led (o_out.status_led),
    .i_ctrl_mode  (o_out.ctrl_mode),
    .i_stepped    (o_out.stepped)
);

`default_nettype wire
